// ===== design/ssl_pkg.sv =====
// ----------------------------------------------------------------------------
// ssl_pkg: shared types and constants of the setpoint slew limiter
// Field widths, register map, sequencer states and serial unit operations.
// ----------------------------------------------------------------------------
package ssl_pkg;

    localparam int unsigned CoordW  = 24;
    localparam int unsigned DtW     = 20;
    localparam int unsigned CfgW    = 16;
    localparam int unsigned UsPerS  = 1000000;

    // Register defaults
    localparam logic [CfgW-1:0] XySpeedRst = 16'd1000;
    localparam logic [CfgW-1:0] ZSpeedRst  = 16'd500;
    localparam logic [CfgW-1:0] TolXyRst   = 16'd200;
    localparam logic [CfgW-1:0] TolZRst    = 16'd150;

    // Register indexes
    localparam logic [1:0] RegXySpeed = 2'd0;
    localparam logic [1:0] RegZSpeed  = 2'd1;
    localparam logic [1:0] RegTolXy   = 2'd2;
    localparam logic [1:0] RegTolZ    = 2'd3;

    localparam logic FuncStep = 1'b0;
    localparam logic FuncLoad = 1'b1;

    // Serial unit operations
    localparam logic [1:0] ModeMul  = 2'd0;
    localparam logic [1:0] ModeDiv  = 2'd1;
    localparam logic [1:0] ModeSqrt = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP_MUL,
        ST_STEP_DIV,
        ST_SQUARE,
        ST_SQRT,
        ST_ADV_MUL,
        ST_ADV_DIV,
        ST_DONE
    } ssl_state_t;

endpackage

// ===== design/ssl_stream_if.sv =====
// ----------------------------------------------------------------------------
// ssl_stream_if: valid/ready channel with a generic payload
// One transfer happens at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface ssl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== design/setpoint_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// setpoint_slew_limiter: 3D position setpoint with slew-rate limit
// ----------------------------------------------------------------------------
// One tick at a time, all arithmetic through one shared bit-serial unit of 64
// bits: a multiply, divide or root is launched, stepped bit by bit and then
// collected. Every tick first runs three squares for the arrival check. A
// load tick (func 1) then finishes. A step tick adds two squares for the
// distance and two multiply/divide pairs for the step lengths; a snap to the
// target ends there, otherwise one root and two more multiply/divide pairs
// follow. The result sits in an output register until taken; the next tick
// is accepted in the cycle after it has gone.
// ----------------------------------------------------------------------------
module setpoint_slew_limiter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ssl_stream_if.sink   in_ch,
    ssl_stream_if.source out_ch
);
    localparam int unsigned W     = 64;
    localparam int unsigned CW    = ssl_pkg::CoordW;
    localparam int unsigned StepW = 17;   // largest step: 65535 * 1048575 / 1e6

    logic [ssl_pkg::CfgW-1:0] xy_speed, z_speed, tol_xy, tol_z;

    ssl_cfg_regs u_cfg (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .xy_speed, .z_speed, .tol_xy, .tol_z
    );

    ssl_pkg::ssl_state_t state_reg, state_next;
    logic [2:0] sub_reg, sub_next;            // operation index inside a state
    logic signed [CW-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [CW-1:0] sx_next, sy_next, sz_next;
    logic signed [CW-1:0] tx_reg, ty_reg, tz_reg;
    logic [ssl_pkg::DtW-1:0] dt_reg;
    logic signed [CW:0]   dx_reg, dy_reg, dz_reg;
    logic [W-1:0] t0_reg, t0_next, t1_reg, t1_next;   // scratch: steps, d2, root
    logic [W-1:0] t2_reg, t2_next;
    logic         arr_reg, arr_next;
    logic         ov_reg, ov_next;                     // output valid
    logic         launched_reg, launched_next;

    logic         u_start, u_busy;
    logic [1:0]   u_mode;
    logic [W-1:0] u_a, u_b, u_res;

    ssl_serial_unit #(.W(W)) u_ser (
        .clk, .rst_n, .start(u_start), .mode(u_mode), .op_a(u_a), .op_b(u_b),
        .busy(u_busy), .result(u_res)
    );

    // arrival check: parallel narrow compares with one square each cycle is
    // avoided; squares taken from the serial unit instead
    logic signed [CW:0] ex, ey, ez;
    logic [CW:0] abs_ex, abs_ey, abs_ez, abs_dx, abs_dy, abs_dz;
    always_comb
    begin
        ex = {in_ch.data.target_x[CW-1], in_ch.data.target_x}
           - {in_ch.data.meas_x[CW-1], in_ch.data.meas_x};
        ey = {in_ch.data.target_y[CW-1], in_ch.data.target_y}
           - {in_ch.data.meas_y[CW-1], in_ch.data.meas_y};
        ez = {in_ch.data.target_z[CW-1], in_ch.data.target_z}
           - {in_ch.data.meas_z[CW-1], in_ch.data.meas_z};
        abs_ex = ex[CW] ? -ex : ex;
        abs_ey = ey[CW] ? -ey : ey;
        abs_ez = ez[CW] ? -ez : ez;
        abs_dx = dx_reg[CW] ? -dx_reg : dx_reg;
        abs_dy = dy_reg[CW] ? -dy_reg : dy_reg;
        abs_dz = dz_reg[CW] ? -dz_reg : dz_reg;
    end

    // square of the horizontal step, narrow since the step fits 17 bits
    logic [StepW-1:0]   step_xy;
    logic [2*StepW-1:0] step_sq;
    always_comb
    begin
        step_xy = t0_reg[StepW-1:0];
        step_sq = step_xy * step_xy;
    end

    logic in_fire, out_fire;
    assign in_ch.ready = (state_reg == ssl_pkg::ST_IDLE) && !ov_reg;
    assign in_fire     = in_ch.valid & in_ch.ready;
    assign out_fire    = out_ch.valid & out_ch.ready;

    // captured arrival error magnitudes
    logic [CW:0] aex_reg, aey_reg;
    logic        azok_reg;
    logic        func_reg;
    logic [W-1:0] adv_q;
    logic signed [CW+1:0] adv_s;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        sub_next      = sub_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        sz_next       = sz_reg;
        t0_next       = t0_reg;
        t1_next       = t1_reg;
        t2_next       = t2_reg;
        arr_next      = arr_reg;
        ov_next       = ov_reg;
        launched_next = launched_reg;
        u_start       = 1'b0;
        u_mode        = ssl_pkg::ModeMul;
        u_a           = '0;
        u_b           = '0;
        adv_q         = '0;
        adv_s         = '0;
        if (out_fire)
            ov_next = 1'b0;
        case (state_reg)
            ssl_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    sub_next      = '0;
                    launched_next = 1'b0;
                    t2_next       = '0;
                    if (in_ch.data.func == ssl_pkg::FuncLoad)
                    begin
                        sx_next = in_ch.data.meas_x;
                        sy_next = in_ch.data.meas_y;
                        sz_next = in_ch.data.meas_z;
                    end
                    state_next = ssl_pkg::ST_SQUARE;   // arrival squares first
                end
            end
            ssl_pkg::ST_SQUARE:
            begin
                // sub 0: ex^2, 1: ey^2, 2: tol^2 -> arrival; 3: dx^2, 4: dy^2
                if (!launched_reg)
                begin
                    u_start = 1'b1;
                    u_mode  = ssl_pkg::ModeMul;
                    case (sub_reg)
                        3'd0: begin u_a = W'(aex_reg); u_b = W'(aex_reg); end
                        3'd1: begin u_a = W'(aey_reg); u_b = W'(aey_reg); end
                        3'd2: begin u_a = W'(tol_xy);  u_b = W'(tol_xy);  end
                        3'd3: begin u_a = W'(abs_dx);  u_b = W'(abs_dx);  end
                        default: begin u_a = W'(abs_dy); u_b = W'(abs_dy); end
                    endcase
                    launched_next = 1'b1;
                end
                else if (!u_busy)
                begin
                    launched_next = 1'b0;
                    sub_next      = sub_reg + 3'd1;
                    case (sub_reg)
                        3'd0: t2_next = u_res;
                        3'd1: t2_next = t2_reg + u_res;
                        3'd2:
                        begin
                            arr_next = (t2_reg <= u_res) && azok_reg;
                            if (func_reg == ssl_pkg::FuncLoad)
                                state_next = ssl_pkg::ST_DONE;
                        end
                        3'd3: t2_next = u_res;
                        default:
                        begin
                            t2_next    = t2_reg + u_res;   // d2
                            sub_next   = '0;
                            state_next = ssl_pkg::ST_STEP_MUL;
                        end
                    endcase
                end
            end
            ssl_pkg::ST_STEP_MUL:
            begin
                // sub 0: xy speed*dt, 1: z speed*dt
                if (!launched_reg)
                begin
                    u_start = 1'b1;
                    u_mode  = ssl_pkg::ModeMul;
                    u_a = W'(sub_reg[0] ? z_speed : xy_speed);
                    u_b = W'(dt_reg);
                    launched_next = 1'b1;
                end
                else if (!u_busy)
                begin
                    launched_next = 1'b0;
                    t1_next       = u_res;
                    state_next    = ssl_pkg::ST_STEP_DIV;
                end
            end
            ssl_pkg::ST_STEP_DIV:
            begin
                if (!launched_reg)
                begin
                    u_start = 1'b1;
                    u_mode  = ssl_pkg::ModeDiv;
                    u_a = t1_reg;
                    u_b = W'(ssl_pkg::UsPerS);
                    launched_next = 1'b1;
                end
                else if (!u_busy)
                begin
                    launched_next = 1'b0;
                    if (sub_reg[0])
                    begin
                        // vertical clamp
                        if (!dz_reg[CW] && W'(abs_dz) > u_res)
                            sz_next = CW'(sz_reg + u_res[CW-1:0]);
                        else if (dz_reg[CW] && W'(abs_dz) > u_res)
                            sz_next = CW'(sz_reg - u_res[CW-1:0]);
                        else
                            sz_next = tz_reg;
                        // horizontal: snap or iterate
                        if (t2_reg == '0 || W'(step_sq) >= t2_reg)
                        begin
                            sx_next    = tx_reg;
                            sy_next    = ty_reg;
                            state_next = ssl_pkg::ST_DONE;
                        end
                        else
                        begin
                            sub_next   = '0;
                            state_next = ssl_pkg::ST_SQRT;
                        end
                    end
                    else
                    begin
                        t0_next    = u_res;             // step_xy
                        sub_next   = 3'd1;
                        state_next = ssl_pkg::ST_STEP_MUL;
                    end
                end
            end
            ssl_pkg::ST_SQRT:
            begin
                if (!launched_reg)
                begin
                    u_start = 1'b1;
                    u_mode  = ssl_pkg::ModeSqrt;
                    u_a = t2_reg;
                    launched_next = 1'b1;
                end
                else if (!u_busy)
                begin
                    launched_next = 1'b0;
                    t2_next       = u_res;              // root of d2
                    state_next    = ssl_pkg::ST_ADV_MUL;
                end
            end
            ssl_pkg::ST_ADV_MUL:
            begin
                // sub 0: |dx|*step, 1: |dy|*step
                if (!launched_reg)
                begin
                    u_start = 1'b1;
                    u_mode  = ssl_pkg::ModeMul;
                    u_a = W'(sub_reg[0] ? abs_dy : abs_dx);
                    u_b = t0_reg;
                    launched_next = 1'b1;
                end
                else if (!u_busy)
                begin
                    launched_next = 1'b0;
                    t1_next       = u_res;
                    state_next    = ssl_pkg::ST_ADV_DIV;
                end
            end
            ssl_pkg::ST_ADV_DIV:
            begin
                if (!launched_reg)
                begin
                    u_start = 1'b1;
                    u_mode  = ssl_pkg::ModeDiv;
                    u_a = t1_reg;
                    u_b = t2_reg;
                    launched_next = 1'b1;
                end
                else if (!u_busy)
                begin
                    launched_next = 1'b0;
                    adv_q = u_res;
                    // quotient below |d| so it fits; apply the sign of d
                    if (sub_reg[0])
                    begin
                        adv_s   = dy_reg[CW] ? -$signed({1'b0, adv_q[CW:0]})
                                             : $signed({1'b0, adv_q[CW:0]});
                        sy_next = CW'(adv_s + (CW+2)'(sy_reg));
                        state_next = ssl_pkg::ST_DONE;
                    end
                    else
                    begin
                        adv_s   = dx_reg[CW] ? -$signed({1'b0, adv_q[CW:0]})
                                             : $signed({1'b0, adv_q[CW:0]});
                        sx_next = CW'(adv_s + (CW+2)'(sx_reg));
                        sub_next   = 3'd1;
                        state_next = ssl_pkg::ST_ADV_MUL;
                    end
                end
            end
            ssl_pkg::ST_DONE:
            begin
                ov_next    = 1'b1;
                state_next = ssl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ssl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ssl_pkg::ST_IDLE;
            sub_reg      <= '0;
            ov_reg       <= 1'b0;
            launched_reg <= 1'b0;
            sx_reg       <= '0;
            sy_reg       <= '0;
            sz_reg       <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            sub_reg      <= sub_next;
            ov_reg       <= ov_next;
            launched_reg <= launched_next;
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
            sz_reg       <= sz_next;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        t2_reg  <= t2_next;
        arr_reg <= arr_next;
        if (in_fire)
        begin
            func_reg <= in_ch.data.func;
            tx_reg   <= in_ch.data.target_x;
            ty_reg   <= in_ch.data.target_y;
            tz_reg   <= in_ch.data.target_z;
            dt_reg   <= in_ch.data.dt_us;
            dx_reg   <= {in_ch.data.target_x[CW-1], in_ch.data.target_x}
                      - {sx_reg[CW-1], sx_reg};
            dy_reg   <= {in_ch.data.target_y[CW-1], in_ch.data.target_y}
                      - {sy_reg[CW-1], sy_reg};
            dz_reg   <= {in_ch.data.target_z[CW-1], in_ch.data.target_z}
                      - {sz_reg[CW-1], sz_reg};
            aex_reg  <= abs_ex;
            aey_reg  <= abs_ey;
            azok_reg <= (abs_ez <= (CW+1)'(tol_z));
        end
    end

    assign out_ch.valid        = ov_reg;
    assign out_ch.data.set_x   = sx_reg;
    assign out_ch.data.set_y   = sy_reg;
    assign out_ch.data.set_z   = sz_reg;
    assign out_ch.data.arrived = arr_reg;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ssl_pkg::ST_IDLE |-> !in_ch.ready)
        else $error("input accepted mid-tick");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ssl_pkg::ST_DONE |=> out_ch.valid)
        else $error("result not presented");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.data.set_x))
        else $error("result changed while stalled");
endmodule

// ===== design/ssl_serial_unit.sv =====
// ----------------------------------------------------------------------------
// ssl_serial_unit: bit-serial multiplier, divider and square root
// Shift-and-add multiply, restoring divide and digit-by-digit root, one bit
// (root: one digit) per cycle. Operands unsigned.
// ----------------------------------------------------------------------------
module ssl_serial_unit #(
    parameter int unsigned W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [1:0]   mode,      // multiply, divide or square root
    input  logic [W-1:0] op_a,
    input  logic [W-1:0] op_b,
    output logic         busy,
    output logic [W-1:0] result
);
    localparam int unsigned CntW = $clog2(W + 1);

    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [1:0]      mode_reg, mode_next;
    logic [W-1:0]    a_reg, a_next;       // multiplicand / dividend / radicand
    logic [W-1:0]    b_reg, b_next;       // multiplier / divisor
    logic [W-1:0]    acc_reg, acc_next;   // product / remainder
    logic [W-1:0]    q_reg, q_next;       // quotient / root
    logic [W:0]      trial;
    logic [W+1:0]    rtrial;
    logic [W+1:0]    rem_sh;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        mode_next = mode_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        trial     = '0;
        rtrial    = '0;
        rem_sh    = '0;
        if (start)
        begin
            busy_next = 1'b1;
            mode_next = mode;
            a_next    = op_a;
            b_next    = op_b;
            acc_next  = '0;
            q_next    = '0;
            cnt_next  = (mode == ssl_pkg::ModeSqrt) ? CntW'(W / 2) : CntW'(W);
        end
        else if (busy_reg)
        begin
            case (mode_reg)
                ssl_pkg::ModeMul:
                begin
                    // add shifted multiplicand when low multiplier bit set
                    if (b_reg[0])
                        acc_next = acc_reg + a_reg;
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
                ssl_pkg::ModeDiv:
                begin
                    trial  = {acc_reg, a_reg[W-1]} - {1'b0, b_reg};
                    a_next = a_reg << 1;
                    if (!trial[W])
                    begin
                        acc_next = trial[W-1:0];
                        q_next   = {q_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = {acc_reg[W-2:0], a_reg[W-1]};
                        q_next   = {q_reg[W-2:0], 1'b0};
                    end
                end
                ssl_pkg::ModeSqrt:
                begin
                    // bring down two radicand bits, try root*4+1
                    rem_sh = {acc_reg, a_reg[W-1:W-2]};
                    rtrial = rem_sh - {q_reg, 2'b01};
                    a_next = a_reg << 2;
                    if (!rtrial[W+1])
                    begin
                        acc_next = rtrial[W-1:0];
                        q_next   = {q_reg[W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = rem_sh[W-1:0];
                        q_next   = {q_reg[W-2:0], 1'b0};
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
            cnt_next = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            mode_reg <= ssl_pkg::ModeMul;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
    end

    assign busy   = busy_reg | start;
    assign result = (mode_reg == ssl_pkg::ModeMul) ? acc_reg : q_reg;

    a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && cnt_reg == CntW'(1) && !start |=> !busy_reg)
        else $error("serial unit did not stop at last step");
    a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("serial unit busy with zero count");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("serial unit did not start");
endmodule

// ===== design/ssl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ssl_cfg_regs: APB register file for speed limits and tolerances
// Four 16-bit registers at byte addresses 0, 4, 8 and 12.
// ----------------------------------------------------------------------------
module ssl_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [3:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output logic [ssl_pkg::CfgW-1:0]  xy_speed,
    output logic [ssl_pkg::CfgW-1:0]  z_speed,
    output logic [ssl_pkg::CfgW-1:0]  tol_xy,
    output logic [ssl_pkg::CfgW-1:0]  tol_z
);
    logic [ssl_pkg::CfgW-1:0] xy_speed_reg, z_speed_reg, tol_xy_reg, tol_z_reg;
    logic [1:0]               idx;
    logic                     wr;
    logic [ssl_pkg::CfgW-1:0] rd;

    assign idx    = paddr[3:2];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xy_speed_reg <= ssl_pkg::XySpeedRst;
            z_speed_reg  <= ssl_pkg::ZSpeedRst;
            tol_xy_reg   <= ssl_pkg::TolXyRst;
            tol_z_reg    <= ssl_pkg::TolZRst;
        end
        else if (wr)
        begin
            case (idx)
                ssl_pkg::RegXySpeed: xy_speed_reg <= pwdata[ssl_pkg::CfgW-1:0];
                ssl_pkg::RegZSpeed:  z_speed_reg  <= pwdata[ssl_pkg::CfgW-1:0];
                ssl_pkg::RegTolXy:   tol_xy_reg   <= pwdata[ssl_pkg::CfgW-1:0];
                ssl_pkg::RegTolZ:    tol_z_reg    <= pwdata[ssl_pkg::CfgW-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            ssl_pkg::RegXySpeed: rd = xy_speed_reg;
            ssl_pkg::RegZSpeed:  rd = z_speed_reg;
            ssl_pkg::RegTolXy:   rd = tol_xy_reg;
            ssl_pkg::RegTolZ:    rd = tol_z_reg;
            default:             rd = '0;
        endcase
    end

    assign prdata   = {16'd0, rd};
    assign xy_speed = xy_speed_reg;
    assign z_speed  = z_speed_reg;
    assign tol_xy   = tol_xy_reg;
    assign tol_z    = tol_z_reg;
endmodule
